@@ rtl/core/swdo_pkg.sv @@
// Package for the stereo wet/dry output chain: field widths, register
// codes, reset values and the structs passed between top level and lanes.
// No dependencies.
package swdo_pkg;

  // sample and coefficient widths
  localparam int DATA_W   = 24;
  localparam int CFG_W    = 17;
  localparam int POLE_W   = 16;
  localparam int IDX_W    = 2;
  localparam int FRAC_W   = 16;
  localparam int MUL_BITS = 16;

  // shared datapath widths inside a lane
  localparam int ST_W  = 32;          // filter state words
  localparam int MC_W  = ST_W + 1;    // multiplicand, holds a difference of two states
  localparam int ACC_W = 50;          // state * 2^16 + coeff * difference

  localparam int DEF_FADE_LENGTH = 2048;
  localparam int OUT_LIMIT       = 5033164;   // 1.2 in Q2.22

  localparam logic [CFG_W-1:0]  COEF_ONE  = 17'h10000;
  localparam logic [CFG_W-1:0]  MIX_RST   = 17'd0;
  localparam logic [POLE_W-1:0] POLE_RST  = 16'd65208;
  localparam logic [CFG_W-1:0]  COEFF_RST = 17'd55706;

  // register index codes
  localparam logic [IDX_W-1:0] REG_MIX   = 2'd0;
  localparam logic [IDX_W-1:0] REG_POLE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_COEFF = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]  mix;
    logic [POLE_W-1:0] pole;
    logic [CFG_W-1:0]  coeff;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic                fade_on;
    logic [MUL_BITS-1:0] fade_num;
  } ctrl_t;

endpackage

@@ rtl/core/swdo_chan.sv @@
// One channel of the output chain: fade divide, mix, DC blocker and lowpass
// on a shared bit-serial multiply/divide accumulator.
// Depends on swdo_pkg.
module swdo_chan #(
  parameter int FADE_LENGTH = swdo_pkg::DEF_FADE_LENGTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swdo_pkg::ctrl_t                     ctrl,
  input  swdo_pkg::cfg_t                      cfg,
  input  logic signed [swdo_pkg::DATA_W-1:0]  dry,
  input  logic signed [swdo_pkg::DATA_W-1:0]  wet,
  output logic signed [swdo_pkg::DATA_W-1:0]  result,
  output logic                                done
);

  localparam int DATA_W = swdo_pkg::DATA_W;
  localparam int ST_W   = swdo_pkg::ST_W;
  localparam int MC_W   = swdo_pkg::MC_W;
  localparam int ACC_W  = swdo_pkg::ACC_W;
  localparam int MB     = swdo_pkg::MUL_BITS;
  localparam int FRAC_W = swdo_pkg::FRAC_W;
  localparam int RND_W  = ACC_W - FRAC_W;
  localparam int QB     = DATA_W - 1;               // quotient bits of the fade divide
  localparam int DW     = $clog2(FADE_LENGTH);      // divide remainder bits
  localparam int CNT_W  = $clog2(QB);
  localparam logic [DW:0]            DIVISOR  = (DW+1)'(FADE_LENGTH);
  localparam logic [CNT_W-1:0]       MUL_LAST = CNT_W'(MB - 1);
  localparam logic [CNT_W-1:0]       DIV_LAST = CNT_W'(QB - 1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic signed [RND_W-1:0] LIM_HI   = RND_W'(swdo_pkg::OUT_LIMIT);
  localparam logic signed [RND_W-1:0] LIM_LO   = -LIM_HI;

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_FMUL = 13'h0002,
    S_FDIV = 13'h0004,
    S_FSEL = 13'h0008,
    S_MIXL = 13'h0010,
    S_MIX  = 13'h0020,
    S_MRND = 13'h0040,
    S_DCL  = 13'h0080,
    S_DC   = 13'h0100,
    S_DRND = 13'h0200,
    S_LPL  = 13'h0400,
    S_LP   = 13'h0800,
    S_LRND = 13'h1000
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          cnt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [MC_W-1:0]    mcand;
  logic [MB-1:0]             mplier;
  logic                      wneg;
  logic signed [DATA_W-1:0]  dry_q;
  logic signed [DATA_W-1:0]  w_q;
  logic signed [DATA_W-1:0]  m_q;
  logic signed [DATA_W-1:0]  x1;
  logic signed [ST_W-1:0]    y1;
  logic signed [ST_W-1:0]    lp;

  logic [DATA_W-1:0]         wet_abs;
  logic signed [ACC_W-1:0]   acc_mul;
  logic [DW:0]               rem_t;
  logic                      rem_ge;
  logic [DW:0]               rem_n;
  logic [ACC_W-1:0]          acc_div;
  logic [QB-1:0]             quot;
  logic signed [DATA_W-1:0]  w_sel;
  logic signed [DATA_W:0]    mix_diff;
  logic signed [DATA_W:0]    dc_diff;
  logic signed [ST_W:0]      lp_diff;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [RND_W-1:0]   rnd;
  logic                      ovf;
  logic signed [ST_W-1:0]    rnd_sat;
  logic signed [DATA_W-1:0]  rnd_clamp;

  assign wet_abs = wet[DATA_W-1] ? (~wet + 1'b1) : wet;

  // one multiplier bit per cycle, MSB first
  assign acc_mul = {acc[ACC_W-2:0], 1'b0}
                 + (mplier[MB-1] ? {{(ACC_W-MC_W){mcand[MC_W-1]}}, mcand} : '0);

  // restoring divide by the fade length, one quotient bit per cycle
  assign rem_t   = {acc[QB+DW-1:QB], acc[QB-1]};
  assign rem_ge  = (rem_t >= DIVISOR);
  assign rem_n   = rem_ge ? (rem_t - DIVISOR) : rem_t;
  assign acc_div = {{(ACC_W-QB-DW){1'b0}}, rem_n[DW-1:0], acc[QB-2:0], rem_ge};

  // faded wet sample, truncated toward zero
  assign quot  = acc[QB-1:0];
  assign w_sel = wneg ? (DATA_W'(0) - {1'b0, quot}) : {1'b0, quot};

  assign mix_diff = {w_q[DATA_W-1], w_q} - {dry_q[DATA_W-1], dry_q};
  assign dc_diff  = {m_q[DATA_W-1], m_q} - {x1[DATA_W-1], x1};
  assign lp_diff  = {y1[ST_W-1], y1} - {lp[ST_W-1], lp};

  // round half up, then saturate to the state range or clamp to the output range
  assign acc_r   = acc + RND_HALF;
  assign rnd     = acc_r[ACC_W-1:FRAC_W];
  assign ovf     = (rnd[RND_W-1:ST_W-1] != '0) && (rnd[RND_W-1:ST_W-1] != '1);
  assign rnd_sat = ovf ? (rnd[RND_W-1] ? {1'b1, {(ST_W-1){1'b0}}}
                                       : {1'b0, {(ST_W-1){1'b1}}})
                       : rnd[ST_W-1:0];

  always_comb begin
    priority if (rnd > LIM_HI) begin
      rnd_clamp = DATA_W'(swdo_pkg::OUT_LIMIT);
    end else if (rnd < LIM_LO) begin
      rnd_clamp = -(DATA_W'(swdo_pkg::OUT_LIMIT));
    end else begin
      rnd_clamp = rnd[DATA_W-1:0];
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      x1    <= '0;
      y1    <= '0;
      lp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            done  <= 1'b0;
            cnt   <= '0;
            state <= ctrl.fade_on ? S_FMUL : S_MIXL;
          end
        end
        S_FMUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= S_FSEL;
          end
        end
        S_FSEL: state <= S_MIXL;
        S_MIXL: state <= S_MIX;
        S_MIX: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= S_MRND;
          end
        end
        S_MRND: state <= S_DCL;
        S_DCL: begin
          x1    <= m_q;
          state <= S_DC;
        end
        S_DC: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= S_DRND;
          end
        end
        S_DRND: begin
          y1    <= rnd_sat;
          state <= S_LPL;
        end
        S_LPL: state <= S_LP;
        S_LP: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= S_LRND;
          end
        end
        S_LRND: begin
          lp    <= rnd_sat;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // accumulator and operand registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          dry_q  <= dry;
          w_q    <= wet;
          wneg   <= wet[DATA_W-1];
          acc    <= '0;
          mcand  <= {{(MC_W-DATA_W){1'b0}}, wet_abs};
          mplier <= ctrl.fade_num;
        end
      end
      S_FMUL, S_MIX, S_DC, S_LP: begin
        acc    <= acc_mul;
        mplier <= {mplier[MB-2:0], 1'b0};
      end
      S_FDIV: acc <= acc_div;
      S_FSEL: w_q <= w_sel;
      S_MIXL: begin
        // full wet share needs a seventeenth bit: start from wet, add nothing
        acc    <= cfg.mix[MB] ? {{(ACC_W-DATA_W){w_q[DATA_W-1]}}, w_q}
                              : {{(ACC_W-DATA_W){dry_q[DATA_W-1]}}, dry_q};
        mcand  <= {{(MC_W-DATA_W-1){mix_diff[DATA_W]}}, mix_diff};
        mplier <= cfg.mix[MB] ? '0 : cfg.mix[MB-1:0];
      end
      S_MRND: m_q <= rnd[DATA_W-1:0];
      S_DCL: begin
        acc    <= {{(ACC_W-DATA_W-1){dc_diff[DATA_W]}}, dc_diff};
        mcand  <= {y1[ST_W-1], y1};
        mplier <= cfg.pole;
      end
      S_LPL: begin
        acc    <= cfg.coeff[MB] ? {{(ACC_W-ST_W){y1[ST_W-1]}}, y1}
                                : {{(ACC_W-ST_W){lp[ST_W-1]}}, lp};
        mcand  <= lp_diff;
        mplier <= cfg.coeff[MB] ? '0 : cfg.coeff[MB-1:0];
      end
      S_LRND: result <= rnd_clamp;
      default: ;
    endcase
  end

  // divide remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FDIV |-> {1'b0, acc[QB+DW-1:QB]} < DIVISOR)
    else $error("fade divide remainder out of range");

  // a new transaction only starts on an idle lane
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> state == S_IDLE)
    else $error("start while lane busy");

  // a finished result is only flagged while idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("done flagged outside idle");

endmodule

@@ rtl/core/stereo_wet_dry_output_chain_core.sv @@
// Top level of the stereo wet/dry output chain: handshakes, configuration
// registers, fade counter and output register around two swdo_chan lanes.
// Depends on swdo_pkg and swdo_chan.
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  input    in_valid / in_ready  dry_left dry_right wet_left wet_right fade_restart
//  output   out_valid/out_ready  out_left out_right
//  config   cfg_we               cfg_index cfg_data
//
// A transaction runs from accept to the next accept through the bit-serial
// multiply (three products, plus a fourth for the fade) and, while a wet
// fade runs, the fade divide per lane, so a running fade lengthens it.
// Both lanes run side by side on the same schedule.
// Reset is synchronous; it clears the filter state, fade counter and handshake flags and loads the config reset values.
// A result waiting in the output register does not block the next input; only
// a second finished result waits in the lanes until the output is free.
module stereo_wet_dry_output_chain_core #(
  parameter int FADE_LENGTH = swdo_pkg::DEF_FADE_LENGTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swdo_pkg::DATA_W-1:0]  dry_left,
  input  logic signed [swdo_pkg::DATA_W-1:0]  dry_right,
  input  logic signed [swdo_pkg::DATA_W-1:0]  wet_left,
  input  logic signed [swdo_pkg::DATA_W-1:0]  wet_right,
  input  logic                                fade_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swdo_pkg::DATA_W-1:0]  out_left,
  output logic signed [swdo_pkg::DATA_W-1:0]  out_right,
  input  logic                                cfg_we,
  input  logic [swdo_pkg::IDX_W-1:0]          cfg_index,
  input  logic [swdo_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CW = $clog2(FADE_LENGTH + 1);
  localparam int MB = swdo_pkg::MUL_BITS;
  localparam logic [CW-1:0] FADE_FULL = CW'(FADE_LENGTH);

  swdo_pkg::cfg_t  cfg_q;
  swdo_pkg::ctrl_t ctrl;
  logic [CW-1:0]   fade_count;
  logic [CW-1:0]   fc_eff;
  logic [CW-1:0]   fade_num;
  logic            fade_act;
  logic            busy;
  logic            accept;
  logic            xfer;
  logic            done_l;
  logic            done_r;
  logic signed [swdo_pkg::DATA_W-1:0] res_l;
  logic signed [swdo_pkg::DATA_W-1:0] res_r;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign xfer     = busy && done_l && (!out_valid || out_ready);

  // fade ramp: restart reloads the counter before this sample
  assign fc_eff   = fade_restart ? FADE_FULL : fade_count;
  assign fade_act = (fc_eff != '0);
  assign fade_num = FADE_FULL - fc_eff;

  assign ctrl.start    = accept;
  assign ctrl.fade_on  = fade_act;
  assign ctrl.fade_num = {{(MB-CW){1'b0}}, fade_num};

  swdo_chan #(.FADE_LENGTH(FADE_LENGTH)) u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg_q),
    .dry    (dry_left),
    .wet    (wet_left),
    .result (res_l),
    .done   (done_l)
  );

  swdo_chan #(.FADE_LENGTH(FADE_LENGTH)) u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg_q),
    .dry    (dry_right),
    .wet    (wet_right),
    .result (res_r),
    .done   (done_r)
  );

  // configuration writes, unity clipped on the Q1.16 gains
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.mix   <= swdo_pkg::MIX_RST;
      cfg_q.pole  <= swdo_pkg::POLE_RST;
      cfg_q.coeff <= swdo_pkg::COEFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swdo_pkg::REG_MIX:
          cfg_q.mix <= (cfg_data > swdo_pkg::COEF_ONE) ? swdo_pkg::COEF_ONE : cfg_data;
        swdo_pkg::REG_POLE:
          cfg_q.pole <= cfg_data[swdo_pkg::POLE_W-1:0];
        swdo_pkg::REG_COEFF:
          cfg_q.coeff <= (cfg_data > swdo_pkg::COEF_ONE) ? swdo_pkg::COEF_ONE : cfg_data;
        default: ;
      endcase
    end
  end

  // transaction control and fade counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      fade_count <= '0;
    end else begin
      if (accept) begin
        busy       <= 1'b1;
        fade_count <= fade_act ? (fc_eff - 1'b1) : '0;
      end
      if (xfer) begin
        busy <= 1'b0;
      end
      if (xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (xfer) begin
      out_left  <= res_l;
      out_right <= res_r;
    end
  end

  // both lanes keep the same schedule
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_l == done_r)
    else $error("lanes out of step");

  a_fade_bound: assert property (@(posedge clk) disable iff (rst)
    fade_count <= FADE_FULL)
    else $error("fade counter above fade length");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    cfg_q.mix <= swdo_pkg::COEF_ONE && cfg_q.coeff <= swdo_pkg::COEF_ONE)
    else $error("gain register above unity");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for stereo_wet_dry_output_chain_core: wet fade, mix, DC blocker,
// lowpass and output clamp predicted per transaction and compared on the output channel.
// Depends on swdo_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_top;

  localparam int  DATA_W         = swdo_pkg::DATA_W;
  localparam int  CFG_W          = swdo_pkg::CFG_W;
  localparam int  IDX_W          = swdo_pkg::IDX_W;
  localparam int  POLE_W         = swdo_pkg::POLE_W;
  localparam int  OUT_LIMIT      = swdo_pkg::OUT_LIMIT;
  localparam int  FADE_LEN       = swdo_pkg::DEF_FADE_LENGTH;
  localparam int  SETTLE_CYCLES  = 120;         // beyond the slowest transaction
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3; // unmapped register index

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 24'sh800000;

  localparam longint UNITY_Q16 = 65536;
  localparam longint HALF_Q16  = 32768;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] dry_l;
    logic signed [DATA_W-1:0] dry_r;
    logic signed [DATA_W-1:0] wet_l;
    logic signed [DATA_W-1:0] wet_r;
    logic                     restart;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } stereo_out_t;

  // DUT ports
  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] dry_left     = '0;
  logic signed [DATA_W-1:0] dry_right    = '0;
  logic signed [DATA_W-1:0] wet_left     = '0;
  logic signed [DATA_W-1:0] wet_right    = '0;
  logic                     fade_restart = 1'b0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic signed [DATA_W-1:0] out_left;
  logic signed [DATA_W-1:0] out_right;
  logic                     cfg_we       = 1'b0;
  logic [IDX_W-1:0]         cfg_index    = '0;
  logic [CFG_W-1:0]         cfg_data     = '0;

  // traffic shaping, set by the tests
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  int mismatch_count = 0;
  int result_count   = 0;
  stereo_out_t pending_outputs[$];

  // predictor copy of registers and filter state
  longint mix_q   = swdo_pkg::MIX_RST;
  longint pole_q  = swdo_pkg::POLE_RST;
  longint coeff_q = swdo_pkg::COEFF_RST;
  int     fade_left = 0;
  longint dc_in[2]    = '{0, 0};
  longint dc_out[2]   = '{0, 0};
  longint lp_state[2] = '{0, 0};

  stereo_wet_dry_output_chain_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .dry_left    (dry_left),
    .dry_right   (dry_right),
    .wet_left    (wet_left),
    .wet_right   (wet_right),
    .fade_restart(fade_restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_left    (out_left),
    .out_right   (out_right),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // fade scale, crossfade, DC blocker, lowpass and clamp for one channel
  function automatic logic signed [DATA_W-1:0] filter_channel(input int ch, input longint dry,
      input longint wet, input longint fade_num);
    longint w;
    longint m;
    longint y;
    longint lp;
    w = wet;
    if (fade_num >= 0) w = (wet * fade_num) / FADE_LEN;   // truncates toward zero
    m = ((UNITY_Q16 - mix_q) * dry + mix_q * w + HALF_Q16) >>> 16;
    y = sat32(m - dc_in[ch] + ((pole_q * dc_out[ch] + HALF_Q16) >>> 16));
    dc_in[ch]  = sat32(m);
    dc_out[ch] = y;
    lp = lp_state[ch];
    lp = sat32(lp + ((coeff_q * (y - lp) + HALF_Q16) >>> 16));
    lp_state[ch] = lp;
    if (lp > OUT_LIMIT) lp = OUT_LIMIT;
    if (lp < -OUT_LIMIT) lp = -OUT_LIMIT;
    return lp[DATA_W-1:0];
  endfunction

  function automatic stereo_out_t predict_output(input sample_t s);
    stereo_out_t r;
    longint fade_num;
    fade_num = -1;
    if (s.restart) fade_left = FADE_LEN;
    if (fade_left > 0) begin
      fade_num = FADE_LEN - fade_left;
      fade_left--;
    end
    r.left  = filter_channel(0, longint'($signed(s.dry_l)), longint'($signed(s.wet_l)), fade_num);
    r.right = filter_channel(1, longint'($signed(s.dry_r)), longint'($signed(s.wet_r)), fade_num);
    return r;
  endfunction

  function automatic void apply_register(input logic [IDX_W-1:0] idx,
      input logic [CFG_W-1:0] data);
    case (idx)
      swdo_pkg::REG_MIX:
        mix_q   = (data > swdo_pkg::COEF_ONE) ? swdo_pkg::COEF_ONE : data;
      swdo_pkg::REG_POLE:
        pole_q  = data[POLE_W-1:0];
      swdo_pkg::REG_COEFF:
        coeff_q = (data > swdo_pkg::COEF_ONE) ? swdo_pkg::COEF_ONE : data;
      default: ;  // unmapped index, ignored
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input logic signed [DATA_W-1:0] l,
      input logic signed [DATA_W-1:0] r);
    stereo_out_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected: left %0d right %0d",
                                result_count, l, r));
    end else begin
      want = pending_outputs.pop_front();
      if (l !== want.left)
        report_mismatch($sformatf("result %0d out_left got %0d expected %0d",
                                  result_count, l, want.left));
      if (r !== want.right)
        report_mismatch($sformatf("result %0d out_right got %0d expected %0d",
                                  result_count, r, want.right));
    end
    result_count++;
  endtask

  // output side: check each transaction, random stalls and long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_left, out_right);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_sample(input sample_t s);
    // idle cycles drawn one cycle at a time
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    dry_left     <= s.dry_l;
    dry_right    <= s.dry_r;
    wet_left     <= s.wet_l;
    wet_right    <= s.wet_r;
    fade_restart <= s.restart;
    do @(posedge clk); while (!in_ready);
    pending_outputs.push_back(predict_output(s));
  endtask

  // drop valid, drain all results, then let the lanes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t make_sample(input logic signed [DATA_W-1:0] dl,
      input logic signed [DATA_W-1:0] dr, input logic signed [DATA_W-1:0] wl,
      input logic signed [DATA_W-1:0] wr, input logic rs);
    sample_t s;
    s.dry_l   = dl;
    s.dry_r   = dr;
    s.wet_l   = wl;
    s.wet_r   = wr;
    s.restart = rs;
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_level();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return DATA_W'($signed(r[11:0]));   // small signal around zero
      default: return r[DATA_W-1:0];
    endcase
  endfunction

  function automatic sample_t random_sample(input int restart_permille);
    return make_sample(random_level(), random_level(), random_level(), random_level(),
                       $urandom_range(999) < restart_permille);
  endfunction

  // unity-range coefficient, above-unity codes included
  function automatic logic [CFG_W-1:0] random_unity_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return swdo_pkg::COEF_ONE;
      2: return CFG_W'($urandom_range(65537, 131071));
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_pole();
    case ($urandom_range(4))
      0: return '0;
      1: return 17'h0FFFF;
      2: return CFG_W'($urandom_range(0, 65535));
      default: return CFG_W'($urandom_range(62000, 65535));
    endcase
  endfunction

  task automatic randomize_registers();
    write_reg(swdo_pkg::REG_MIX, random_unity_coeff());
    write_reg(swdo_pkg::REG_POLE, random_pole());
    write_reg(swdo_pkg::REG_COEFF, random_unity_coeff());
    if ($urandom_range(1)) write_reg(REG_NONE, CFG_W'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // reset register values: dry path only, field extremes and DC build-up
  task automatic test_reset_defaults();
    send_sample(make_sample('0, '0, '0, '0, 1'b0));
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    repeat (3) send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, '0, '0, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
  endtask

  // above-unity codes, unmapped index, fade restart and restart mid-fade
  task automatic test_register_extremes();
    wait_idle();
    write_reg(swdo_pkg::REG_MIX, 17'h1FFFF);
    write_reg(swdo_pkg::REG_POLE, 17'h0FFFF);
    write_reg(swdo_pkg::REG_COEFF, 17'h1FFFF);
    write_reg(REG_NONE, 17'h1FFFF);
    send_sample(make_sample('0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    send_sample(make_sample('0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_sample(make_sample('0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0));

    wait_idle();
    write_reg(swdo_pkg::REG_MIX, swdo_pkg::COEF_ONE);
    write_reg(swdo_pkg::REG_POLE, '0);
    write_reg(swdo_pkg::REG_COEFF, '0);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0));

    wait_idle();
    write_reg(swdo_pkg::REG_MIX, 17'd32768);
    write_reg(swdo_pkg::REG_POLE, 17'h0FFFF);
    write_reg(swdo_pkg::REG_COEFF, swdo_pkg::COEF_ONE);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, '0, '0, 1'b1));
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
      input int restart_permille);
    wait_idle();
    randomize_registers();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_sample(random_sample(restart_permille));
  endtask

  // long output stall while input keeps coming: the core must fill and stall its input
  task automatic test_output_backpressure();
    wait_idle();
    randomize_registers();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1500;
    repeat (40) send_sample(random_sample(20));
  endtask

  // fresh restart, start of the wet ramp, then a restart in the middle of it
  task automatic test_fade_restart();
    wait_idle();
    write_reg(swdo_pkg::REG_MIX, CFG_W'($urandom_range(40000, 65536)));
    write_reg(swdo_pkg::REG_POLE, random_pole());
    write_reg(swdo_pkg::REG_COEFF, CFG_W'($urandom_range(30000, 65536)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(make_sample(random_level(), random_level(), SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    repeat (30) send_sample(random_sample(0));
    send_sample(make_sample(random_level(), random_level(), SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    repeat (8) send_sample(random_sample(0));
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_random_traffic(350, 13, 85, 0);   // fade counter still idle
    test_register_extremes();
    test_random_traffic(350, 85, 13, 5);
    test_random_traffic(300, 0, 0, 5);
    test_output_backpressure();
    test_fade_restart();

    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[stereo_wet_dry_output_chain_core] OK");
    end else begin
      $display("[stereo_wet_dry_output_chain_core] ERROR");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #20_000_000;
    $display("[stereo_wet_dry_output_chain_core] ERROR");
    $finish;
  end

endmodule
